@@ rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants and types for the point to triangle squared distance block.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MUL_CHUNK         = 16;

  typedef enum logic [2:0] {
    REG_VA,
    REG_VB,
    REG_VC,
    REG_AB,
    REG_AC,
    REG_BC,
    REG_IN
  } region_t;

endpackage

@@ rtl/ptd_delay.sv @@
// ----------------------------------------------------------------------------
// ptd_delay
// Enabled shift line that carries side data alongside a pipelined unit.
// ----------------------------------------------------------------------------
module ptd_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

@@ rtl/ptd_mul.sv @@
// ----------------------------------------------------------------------------
// ptd_mul
// Pipelined signed multiplier that adds one partial product per stage,
// splitting the second operand into fixed-width chunks.
// ----------------------------------------------------------------------------
module ptd_mul #(
  parameter int WA = 16,
  parameter int WB = 16,
  parameter int CH = ptd_pkg::MUL_CHUNK
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NCH = (WB + CH - 1) / CH;
  localparam int BE  = NCH * CH;
  localparam int PW  = WA + WB;

  logic signed [BE-1:0] bx;
  logic signed [WA-1:0] a_in   [NCH];
  logic signed [BE-1:0] b_in   [NCH];
  logic signed [PW-1:0] acc_in [NCH];
  logic signed [WA-1:0] a_r    [NCH];
  logic signed [BE-1:0] b_r    [NCH];
  logic signed [PW-1:0] acc_r  [NCH];

  assign bx = BE'(b);

  for (genvar i = 0; i < NCH; i++) begin : g_stage
    logic signed [CH:0]      chunk;
    logic signed [WA+CH:0]   part;

    if (i == 0) begin : g_first
      assign a_in[i]   = a;
      assign b_in[i]   = bx;
      assign acc_in[i] = '0;
    end else begin : g_next
      assign a_in[i]   = a_r[i-1];
      assign b_in[i]   = b_r[i-1];
      assign acc_in[i] = acc_r[i-1];
    end

    if (i == NCH - 1) begin : g_top
      assign chunk = {b_in[i][i*CH+CH-1], b_in[i][i*CH +: CH]};
    end else begin : g_low
      assign chunk = {1'b0, b_in[i][i*CH +: CH]};
    end

    assign part = a_in[i] * chunk;

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i]   <= a_in[i];
        b_r[i]   <= b_in[i];
        acc_r[i] <= acc_in[i] + (PW'(part) <<< (i * CH));
      end
    end
  end

  assign p = acc_r[NCH-1];

endmodule

@@ rtl/ptd_div.sv @@
// ----------------------------------------------------------------------------
// ptd_div
// Pipelined restoring divider that settles one quotient bit per stage.
// The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module ptd_div #(
  parameter int DU = 16,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DU-1:0] rem0,
  input  logic [QB-1:0] low,
  input  logic [DU-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DU-1:0] rem_in [QB];
  logic [QB-1:0] low_in [QB];
  logic [DU-1:0] den_in [QB];
  logic [QB-1:0] quo_in [QB];
  logic [DU-1:0] rem_r  [QB];
  logic [QB-1:0] low_r  [QB];
  logic [DU-1:0] den_r  [QB];
  logic [QB-1:0] quo_r  [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DU:0] trial;
    logic [DU:0] diff;
    logic        take;

    if (i == 0) begin : g_first
      assign rem_in[i] = rem0;
      assign low_in[i] = low;
      assign den_in[i] = den;
      assign quo_in[i] = '0;
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign low_in[i] = low_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign quo_in[i] = quo_r[i-1];
    end

    assign trial = {rem_in[i], low_in[i][QB-1]};
    assign take  = trial >= {1'b0, den_in[i]};
    assign diff  = trial - {1'b0, den_in[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? diff[DU-1:0] : trial[DU-1:0];
        low_r[i] <= low_in[i] << 1;
        den_r[i] <= den_in[i];
        quo_r[i] <= (quo_in[i] << 1) | QB'(take);
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

@@ rtl/point_triangle_distance_squared.sv @@
// ----------------------------------------------------------------------------
// point_triangle_distance_squared
// Squared distance from a query point to a triangle in 3D, fully pipelined.
//
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    point and three corners
// out_     output     out_valid / out_stall  squared distance, degenerate flag
//
// One transaction is accepted every cycle while the output is not stalled.
// The divider settles one quotient bit per stage.
// A stall on a valid output freezes the whole pipeline and raises in_stall.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module point_triangle_distance_squared #(
  parameter int COORD_BITS    = ptd_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = ptd_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [COORD_BITS-1:0]             in_point_x,
  input  logic signed [COORD_BITS-1:0]             in_point_y,
  input  logic signed [COORD_BITS-1:0]             in_point_z,
  input  logic signed [COORD_BITS-1:0]             in_corner_a_x,
  input  logic signed [COORD_BITS-1:0]             in_corner_a_y,
  input  logic signed [COORD_BITS-1:0]             in_corner_a_z,
  input  logic signed [COORD_BITS-1:0]             in_corner_b_x,
  input  logic signed [COORD_BITS-1:0]             in_corner_b_y,
  input  logic signed [COORD_BITS-1:0]             in_corner_b_z,
  input  logic signed [COORD_BITS-1:0]             in_corner_c_x,
  input  logic signed [COORD_BITS-1:0]             in_corner_c_y,
  input  logic signed [COORD_BITS-1:0]             in_corner_c_z,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [2*COORD_BITS+2+FRACTION_BITS-1:0]  out_squared_distance,
  output logic                                     out_degenerate
);

  localparam int CH  = ptd_pkg::MUL_CHUNK;
  localparam int OB  = 2 * COORD_BITS + 2 + FRACTION_BITS;
  localparam int DIF = COORD_BITS + 1;
  localparam int SQ  = 2 * DIF;
  localparam int DW  = 2 * COORD_BITS + 4;
  localparam int EW  = DW + 3;
  localparam int SW  = 2 * DW + 1;
  localparam int AW  = SW;
  localparam int BW  = EW;
  localparam int NW  = AW + BW + 2;
  localparam int NU  = NW - 1;
  localparam int NF  = NU + FRACTION_BITS;
  localparam int DU  = SW;
  localparam int M1  = (DW + CH - 1) / CH;
  localparam int M2  = (BW + CH - 1) / CH;
  localparam int I3  = 2;
  localparam int I4  = 3 + M1;
  localparam int I6  = 5 + M1;
  localparam int L   = 8 + M1 + M2 + OB;
  localparam int SB1 = 6 * DW + 4 * EW;

  logic en;
  logic vld_r [L];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;
  assign out_valid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < L; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Edge and offset vectors.
  logic signed [DIF-1:0] d_r [3];
  logic signed [DIF-1:0] e0_r [3];
  logic signed [DIF-1:0] e1_r [3];
  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] ac [3];
  logic signed [COORD_BITS-1:0] bc [3];
  logic signed [COORD_BITS-1:0] cc [3];

  assign pc[0] = in_point_x;
  assign pc[1] = in_point_y;
  assign pc[2] = in_point_z;
  assign ac[0] = in_corner_a_x;
  assign ac[1] = in_corner_a_y;
  assign ac[2] = in_corner_a_z;
  assign bc[0] = in_corner_b_x;
  assign bc[1] = in_corner_b_y;
  assign bc[2] = in_corner_b_z;
  assign cc[0] = in_corner_c_x;
  assign cc[1] = in_corner_c_y;
  assign cc[2] = in_corner_c_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= DIF'(ac[i]) - DIF'(pc[i]);
        e0_r[i] <= DIF'(bc[i]) - DIF'(ac[i]);
        e1_r[i] <= DIF'(cc[i]) - DIF'(ac[i]);
      end
    end
  end

  // Element products.
  logic signed [SQ-1:0] p00_r [3];
  logic signed [SQ-1:0] p01_r [3];
  logic signed [SQ-1:0] p11_r [3];
  logic signed [SQ-1:0] pb0_r [3];
  logic signed [SQ-1:0] pb1_r [3];
  logic signed [SQ-1:0] pc_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p00_r[i] <= e0_r[i] * e0_r[i];
        p01_r[i] <= e0_r[i] * e1_r[i];
        p11_r[i] <= e1_r[i] * e1_r[i];
        pb0_r[i] <= d_r[i] * e0_r[i];
        pb1_r[i] <= d_r[i] * e1_r[i];
        pc_r[i]  <= d_r[i] * d_r[i];
      end
    end
  end

  // Dot products and derived sums.
  logic signed [DW-1:0] a00_r, a01_r, a11_r, b0_r, b1_r, c_r;
  logic signed [EW-1:0] denom_r, qc_r, qb_r, numer_r;
  logic signed [DW-1:0] a00_nxt, a01_nxt, a11_nxt, b0_nxt, b1_nxt, c_nxt;

  always_comb begin
    a00_nxt = DW'(p00_r[0]) + DW'(p00_r[1]) + DW'(p00_r[2]);
    a01_nxt = DW'(p01_r[0]) + DW'(p01_r[1]) + DW'(p01_r[2]);
    a11_nxt = DW'(p11_r[0]) + DW'(p11_r[1]) + DW'(p11_r[2]);
    b0_nxt  = DW'(pb0_r[0]) + DW'(pb0_r[1]) + DW'(pb0_r[2]);
    b1_nxt  = DW'(pb1_r[0]) + DW'(pb1_r[1]) + DW'(pb1_r[2]);
    c_nxt   = DW'(pc_r[0])  + DW'(pc_r[1])  + DW'(pc_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a00_r   <= a00_nxt;
      a01_r   <= a01_nxt;
      a11_r   <= a11_nxt;
      b0_r    <= b0_nxt;
      b1_r    <= b1_nxt;
      c_r     <= c_nxt;
      denom_r <= EW'(a00_nxt) - (EW'(a01_nxt) <<< 1) + EW'(a11_nxt);
      qc_r    <= EW'(a11_nxt) + (EW'(b1_nxt) <<< 1) + EW'(c_nxt);
      qb_r    <= EW'(a00_nxt) + (EW'(b0_nxt) <<< 1) + EW'(c_nxt);
      numer_r <= EW'(a11_nxt) + EW'(b1_nxt) - EW'(a01_nxt) - EW'(b0_nxt);
    end
  end

  // Cross products for s, t and det.
  logic signed [2*DW-1:0] m_a01b1, m_a11b0, m_a01b0, m_a00b1, m_a00a11, m_a01a01;

  ptd_mul #(.WA(DW), .WB(DW), .CH(CH)) u_mul_a01b1 (
    .clk(clk), .en(en), .a(a01_r), .b(b1_r), .p(m_a01b1));
  ptd_mul #(.WA(DW), .WB(DW), .CH(CH)) u_mul_a11b0 (
    .clk(clk), .en(en), .a(a11_r), .b(b0_r), .p(m_a11b0));
  ptd_mul #(.WA(DW), .WB(DW), .CH(CH)) u_mul_a01b0 (
    .clk(clk), .en(en), .a(a01_r), .b(b0_r), .p(m_a01b0));
  ptd_mul #(.WA(DW), .WB(DW), .CH(CH)) u_mul_a00b1 (
    .clk(clk), .en(en), .a(a00_r), .b(b1_r), .p(m_a00b1));
  ptd_mul #(.WA(DW), .WB(DW), .CH(CH)) u_mul_a00a11 (
    .clk(clk), .en(en), .a(a00_r), .b(a11_r), .p(m_a00a11));
  ptd_mul #(.WA(DW), .WB(DW), .CH(CH)) u_mul_a01a01 (
    .clk(clk), .en(en), .a(a01_r), .b(a01_r), .p(m_a01a01));

  logic [SB1-1:0] sb1_d, sb1_q;

  assign sb1_d = {a00_r, a01_r, a11_r, b0_r, b1_r, c_r, denom_r, qc_r, qb_r, numer_r};

  ptd_delay #(.WIDTH(SB1), .DEPTH(M1)) u_dly_dots (
    .clk(clk), .en(en), .d(sb1_d), .q(sb1_q));

  logic signed [SW-1:0] s4_r, t4_r, det4_r;
  logic [SB1-1:0]       sb4_r;
  logic signed [SW-1:0] det_raw;

  assign det_raw = SW'(m_a00a11) - SW'(m_a01a01);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r   <= SW'(m_a01b1) - SW'(m_a11b0);
      t4_r   <= SW'(m_a01b0) - SW'(m_a00b1);
      det4_r <= det_raw[SW-1] ? -det_raw : det_raw;
      sb4_r  <= sb1_q;
    end
  end

  // Region classification.
  logic signed [DW-1:0] a00_4, a01_4, a11_4, b0_4, b1_4, c_4;
  logic signed [EW-1:0] denom_4, qc_4, qb_4, numer_4;

  assign {a00_4, a01_4, a11_4, b0_4, b1_4, c_4, denom_4, qc_4, qb_4, numer_4} = sb4_r;

  function automatic ptd_pkg::region_t pick_ab(input logic signed [DW-1:0] b,
                                               input logic signed [DW-1:0] a);
    ptd_pkg::region_t r;
    if (b >= 0) begin
      r = ptd_pkg::REG_VA;
    end else if (-b >= a) begin
      r = ptd_pkg::REG_VB;
    end else begin
      r = ptd_pkg::REG_AB;
    end
    return r;
  endfunction

  function automatic ptd_pkg::region_t pick_ac(input logic signed [DW-1:0] b,
                                               input logic signed [DW-1:0] a);
    ptd_pkg::region_t r;
    if (b >= 0) begin
      r = ptd_pkg::REG_VA;
    end else if (-b >= a) begin
      r = ptd_pkg::REG_VC;
    end else begin
      r = ptd_pkg::REG_AC;
    end
    return r;
  endfunction

  ptd_pkg::region_t     reg_nxt, reg5_r;
  logic signed [SW:0]   st_sum;
  logic signed [EW-1:0] tmp0, tmp1;

  always_comb begin
    st_sum  = (SW+1)'(s4_r) + (SW+1)'(t4_r);
    tmp0    = '0;
    tmp1    = '0;
    reg_nxt = ptd_pkg::REG_IN;
    if ((SW+1)'(det4_r) >= st_sum) begin
      if (s4_r < 0) begin
        if (t4_r < 0 && b0_4 < 0) begin
          reg_nxt = pick_ab(b0_4, a00_4);
        end else begin
          reg_nxt = pick_ac(b1_4, a11_4);
        end
      end else if (t4_r < 0) begin
        reg_nxt = pick_ab(b0_4, a00_4);
      end else begin
        reg_nxt = ptd_pkg::REG_IN;
      end
    end else if (s4_r < 0) begin
      tmp0 = EW'(a01_4) + EW'(b0_4);
      tmp1 = EW'(a11_4) + EW'(b1_4);
      if (tmp1 > tmp0) begin
        reg_nxt = (tmp1 - tmp0 >= denom_4) ? ptd_pkg::REG_VB : ptd_pkg::REG_BC;
      end else if (tmp1 <= 0) begin
        reg_nxt = ptd_pkg::REG_VC;
      end else begin
        reg_nxt = pick_ac(b1_4, a11_4);
      end
    end else if (t4_r < 0) begin
      tmp0 = EW'(a01_4) + EW'(b1_4);
      tmp1 = EW'(a00_4) + EW'(b0_4);
      if (tmp1 > tmp0) begin
        reg_nxt = (tmp1 - tmp0 >= denom_4) ? ptd_pkg::REG_VC : ptd_pkg::REG_BC;
      end else if (tmp1 <= 0) begin
        reg_nxt = ptd_pkg::REG_VB;
      end else begin
        reg_nxt = pick_ab(b0_4, a00_4);
      end
    end else begin
      if (numer_4 <= 0) begin
        reg_nxt = ptd_pkg::REG_VC;
      end else begin
        reg_nxt = (numer_4 >= denom_4) ? ptd_pkg::REG_VB : ptd_pkg::REG_BC;
      end
    end
  end

  logic signed [SW-1:0] s5_r, t5_r, det5_r;
  logic [SB1-1:0]       sb5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      reg5_r <= reg_nxt;
      s5_r   <= s4_r;
      t5_r   <= t4_r;
      det5_r <= det4_r;
      sb5_r  <= sb4_r;
    end
  end

  // Operand selection for the numerator.
  logic signed [DW-1:0] a00_5, a01_5, a11_5, b0_5, b1_5, c_5;
  logic signed [EW-1:0] denom_5, qc_5, qb_5, numer_5;

  assign {a00_5, a01_5, a11_5, b0_5, b1_5, c_5, denom_5, qc_5, qb_5, numer_5} = sb5_r;

  logic signed [AW-1:0] x1_nxt, x2_nxt, x3_nxt;
  logic signed [BW-1:0] y1_nxt, y2_nxt, y3_nxt;
  logic signed [SW-1:0] den_sel;
  logic                 neg_nxt, deg_nxt;

  always_comb begin
    x1_nxt  = AW'(c_5);
    y1_nxt  = BW'(1);
    x2_nxt  = '0;
    y2_nxt  = '0;
    x3_nxt  = '0;
    y3_nxt  = '0;
    neg_nxt = 1'b0;
    den_sel = SW'(1);
    case (reg5_r)
      ptd_pkg::REG_VA: begin
        x1_nxt = AW'(c_5);
      end
      ptd_pkg::REG_VB: begin
        x1_nxt = AW'(qb_5);
      end
      ptd_pkg::REG_VC: begin
        x1_nxt = AW'(qc_5);
      end
      ptd_pkg::REG_AB: begin
        x1_nxt  = AW'(c_5);
        y1_nxt  = BW'(a00_5);
        x2_nxt  = AW'(b0_5);
        y2_nxt  = BW'(b0_5);
        neg_nxt = 1'b1;
        den_sel = SW'(a00_5);
      end
      ptd_pkg::REG_AC: begin
        x1_nxt  = AW'(c_5);
        y1_nxt  = BW'(a11_5);
        x2_nxt  = AW'(b1_5);
        y2_nxt  = BW'(b1_5);
        neg_nxt = 1'b1;
        den_sel = SW'(a11_5);
      end
      ptd_pkg::REG_BC: begin
        x1_nxt  = AW'(qc_5);
        y1_nxt  = denom_5;
        x2_nxt  = AW'(numer_5);
        y2_nxt  = numer_5;
        neg_nxt = 1'b1;
        den_sel = SW'(denom_5);
      end
      ptd_pkg::REG_IN: begin
        x1_nxt  = det5_r;
        y1_nxt  = BW'(c_5);
        x2_nxt  = s5_r;
        y2_nxt  = BW'(b0_5);
        x3_nxt  = t5_r;
        y3_nxt  = BW'(b1_5);
        den_sel = det5_r;
      end
      default: begin
        x1_nxt = AW'(c_5);
      end
    endcase
    deg_nxt = (den_sel <= 0);
    if (deg_nxt) begin
      x1_nxt  = AW'(c_5);
      y1_nxt  = BW'(1);
      x2_nxt  = '0;
      x3_nxt  = '0;
      den_sel = SW'(1);
    end
  end

  logic signed [AW-1:0] x1_r, x2_r, x3_r;
  logic signed [BW-1:0] y1_r, y2_r, y3_r;
  logic signed [SW-1:0] den6_r;
  logic                 neg6_r, deg6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x1_nxt;
      y1_r   <= y1_nxt;
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      x3_r   <= x3_nxt;
      y3_r   <= y3_nxt;
      den6_r <= den_sel;
      neg6_r <= neg_nxt;
      deg6_r <= deg_nxt;
    end
  end

  logic signed [AW+BW-1:0] m1, m2, m3;

  ptd_mul #(.WA(AW), .WB(BW), .CH(CH)) u_mul_n1 (
    .clk(clk), .en(en), .a(x1_r), .b(y1_r), .p(m1));
  ptd_mul #(.WA(AW), .WB(BW), .CH(CH)) u_mul_n2 (
    .clk(clk), .en(en), .a(x2_r), .b(y2_r), .p(m2));
  ptd_mul #(.WA(AW), .WB(BW), .CH(CH)) u_mul_n3 (
    .clk(clk), .en(en), .a(x3_r), .b(y3_r), .p(m3));

  logic [SW+1:0] sb2_q;
  logic signed [SW-1:0] den_m;
  logic                 neg_m, deg_m;

  ptd_delay #(.WIDTH(SW+2), .DEPTH(M2)) u_dly_num (
    .clk(clk), .en(en), .d({den6_r, neg6_r, deg6_r}), .q(sb2_q));

  assign {den_m, neg_m, deg_m} = sb2_q;

  // Numerator assembly, clamped at zero.
  logic signed [NW-1:0] num_sum;
  logic [NU-1:0]        num7_r;
  logic [DU-1:0]        den7_r;
  logic                 deg7_r;

  assign num_sum = NW'(m1) + (neg_m ? -NW'(m2) : NW'(m2)) + NW'(m3);

  always_ff @(posedge clk) begin
    if (en) begin
      num7_r <= num_sum[NW-1] ? '0 : num_sum[NU-1:0];
      den7_r <= DU'(den_m);
      deg7_r <= deg_m;
    end
  end

  // Divider setup and overflow check.
  logic [NF-1:0] num_scaled, rem_full;
  logic          ovf_nxt;
  logic [DU-1:0] rem8_r, den8_r;
  logic [OB-1:0] low8_r;
  logic          ovf8_r, deg8_r;

  assign num_scaled = NF'(num7_r) << FRACTION_BITS;
  assign rem_full   = num_scaled >> OB;
  assign ovf_nxt    = rem_full >= NF'(den7_r);

  always_ff @(posedge clk) begin
    if (en) begin
      rem8_r <= ovf_nxt ? '0 : rem_full[DU-1:0];
      low8_r <= num_scaled[OB-1:0];
      den8_r <= den7_r;
      ovf8_r <= ovf_nxt;
      deg8_r <= deg7_r;
    end
  end

  logic [OB-1:0] quo;
  logic          ovf_q, deg_q;

  ptd_div #(.DU(DU), .QB(OB)) u_div (
    .clk(clk), .en(en), .rem0(rem8_r), .low(low8_r), .den(den8_r), .quo(quo));

  ptd_delay #(.WIDTH(2), .DEPTH(OB)) u_dly_div (
    .clk(clk), .en(en), .d({ovf8_r, deg8_r}), .q({ovf_q, deg_q}));

  assign out_squared_distance = ovf_q ? '1 : quo;
  assign out_degenerate       = deg_q;

  a_a00_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[I3] |-> !a00_r[DW-1])
    else $error("self dot product a00 is negative");

  a_det_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[I4] |-> !det4_r[SW-1])
    else $error("determinant magnitude is negative");

  a_deg_unit_den : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[I6] && deg6_r) |-> (den6_r == SW'(1) && x2_r == '0 && x3_r == '0))
    else $error("degenerate transaction does not fall back to corner A");

endmodule
